[hw/rtl/dps_pkg.sv]
// ----------------------------------------------------------------------------
// dps_pkg: shared types, constants and helpers of the damped pendulum step
// Fixed-point constants, the CORDIC arctangent table and rounding helpers.
// ----------------------------------------------------------------------------
package dps_pkg;

  // default parameter values
  localparam int ANGLE_FRAC_BITS_DEF = 16;
  localparam int CORDIC_STEPS_DEF    = 16;

  // arctangent table length and CORDIC datapath width
  localparam int TAB_LEN = 24;
  localparam int CW      = 34;
  // width of the shared multiplier product
  localparam int MW      = 57;

  // pi in Q4.60 and the CORDIC start vector in Q2.30
  localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
  localparam logic [31:0] GAIN_Q30 = 32'd652032874;
  // pi/180 in Q0.32, rounded
  localparam logic [63:0] DEG_Q32  = ((PI_Q60 / 180) + (64'd1 << 27)) >> 28;

  // reset values of configuration and state
  localparam logic [9:0]  PIVOT_X_RST = 10'd400;
  localparam logic [9:0]  PIVOT_Y_RST = 10'd10;
  localparam logic [23:0] GRAVITY_RST = 24'd642253;
  localparam logic [16:0] DAMPING_RST = 17'd65208;
  localparam logic [14:0] LENGTH_RST  = 15'd4800;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_PIVOT_X = 2'd0,
    REG_PIVOT_Y = 2'd1,
    REG_GRAVITY = 2'd2,
    REG_DAMPING = 2'd3
  } cfg_reg_t;

  // request to the CORDIC unit
  typedef struct packed {
    logic                 start;
    logic                 vec;
    logic signed [CW-1:0] x0;
    logic signed [CW-1:0] y0;
    logic signed [CW-1:0] z0;
  } cor_req_t;

  // atan(2^-i) in Q2.30
  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'h3243F6A8;
      5'd1:  v = 30'h1DAC6705;
      5'd2:  v = 30'h0FADBAFC;
      5'd3:  v = 30'h07F56EA6;
      5'd4:  v = 30'h03FEAB76;
      5'd5:  v = 30'h01FFD55B;
      5'd6:  v = 30'h00FFFAAA;
      5'd7:  v = 30'h007FFF55;
      5'd8:  v = 30'h003FFFEA;
      5'd9:  v = 30'h001FFFFD;
      5'd10: v = 30'h000FFFFF;
      5'd11: v = 30'h0007FFFF;
      5'd12: v = 30'h0003FFFF;
      5'd13: v = 30'h0001FFFF;
      5'd14: v = 30'h0000FFFF;
      5'd15: v = 30'h00007FFF;
      5'd16: v = 30'h00003FFF;
      5'd17: v = 30'h00001FFF;
      5'd18: v = 30'h00000FFF;
      5'd19: v = 30'h000007FF;
      5'd20: v = 30'h000003FF;
      5'd21: v = 30'h000001FF;
      5'd22: v = 30'h000000FF;
      5'd23: v = 30'h0000007F;
      default: v = 30'h0;
    endcase
    return v;
  endfunction

  // right shift by a constant, round to nearest with ties away from zero
  function automatic logic signed [MW-1:0] rnd_shift(input logic signed [MW-1:0] v,
                                                     input int s);
    logic [MW-1:0] m;
    m = v[MW-1] ? MW'(-v) : MW'(v);
    m = (m + (MW'(1) << (s - 1))) >> s;
    return v[MW-1] ? -$signed(m) : $signed(m);
  endfunction

  // clamp to a signed range of the given width
  function automatic logic signed [MW-1:0] sat_w(input logic signed [MW-1:0] v,
                                                 input int bits);
    logic signed [MW-1:0] hi;
    logic signed [MW-1:0] lo;
    hi = (MW'(1) << (bits - 1)) - MW'(1);
    lo = ~hi;
    if (v > hi) return hi;
    else if (v < lo) return lo;
    else return v;
  endfunction

endpackage

[hw/rtl/dps_cordic.sv]
// ----------------------------------------------------------------------------
// dps_cordic: iterative CORDIC, one micro-rotation per cycle
// Rotation mode gives sine and cosine, vectoring mode gives an arctangent.
// ----------------------------------------------------------------------------
module dps_cordic
  import dps_pkg::*;
#(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cor_req_t             req,
  output logic                 busy,
  output logic signed [CW-1:0] x,
  output logic signed [CW-1:0] y,
  output logic signed [CW-1:0] z
);

  localparam int N  = (STEPS < TAB_LEN) ? STEPS : TAB_LEN;
  localparam int IW = $clog2(N);

  logic                 busy_r;
  logic                 vec_r;
  logic [IW-1:0]        i_r;
  logic signed [CW-1:0] x_r, y_r, z_r;
  logic signed [CW-1:0] x_nxt, y_nxt, z_nxt;
  logic signed [CW-1:0] xs, ys, at;
  logic                 plus, hold;

  // one micro-rotation
  always_comb begin
    xs = x_r >>> i_r;
    ys = y_r >>> i_r;
    at = CW'(atan_q30(5'(i_r)));
    if (vec_r) begin
      plus = y_r < 0;
      hold = (y_r == 0);
    end else begin
      plus = z_r >= 0;
      hold = 1'b0;
    end
    if (hold) begin
      x_nxt = x_r;
      y_nxt = y_r;
      z_nxt = z_r;
    end else if (plus) begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - at;
    end else begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + at;
    end
  end

  // iteration control and vector registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (req.start) begin
      busy_r <= 1'b1;
    end else if (busy_r && i_r == IW'(N - 1)) begin
      busy_r <= 1'b0;
    end
    if (req.start) begin
      vec_r <= req.vec;
      i_r   <= '0;
      x_r   <= req.x0;
      y_r   <= req.y0;
      z_r   <= req.z0;
    end else if (busy_r) begin
      i_r <= i_r + IW'(1);
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign busy = busy_r;
  assign x    = x_r;
  assign y    = y_r;
  assign z    = z_r;

endmodule

[hw/rtl/damped_pendulum_step.sv]
// ----------------------------------------------------------------------------
// damped_pendulum_step: damped pendulum, one Euler step or drag per item
// Keeps angle, velocity and rod length and reports the bob position.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_*  writes pivot_x, pivot_y, gravity and damping by index; always ready.
//          The user must write them only while idle; the block has no check.
//   in_*   one item per transfer; func 0 advances one time step, func 1 drags
//          the bob to (drag_x, drag_y). in_ready is high only while idle.
//   out_*  one result per item: bob position, angle and velocity after it.
// Steps: a time step runs a CORDIC sine pass, the restoring divider and a
//   second CORDIC pass for the bob position; a drag runs the CORDIC
//   arctangent beside the restoring square root.
// Throughput: one item at a time, the next accepted once the sequencer is idle.
// Reset: angle 45 degrees, velocity zero, length 300 pixels, registers at their
//   defaults, output empty.
// Stall: a finished result waits in the output register; a new item may be
//   accepted meanwhile, and its result is held back until the old one is taken.
// ----------------------------------------------------------------------------
module damped_pendulum_step
  import dps_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_func,
  input  logic [9:0]         in_drag_x,
  input  logic [9:0]         in_drag_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_bob_x,
  output logic signed [15:0] out_bob_y,
  output logic signed [18:0] out_swing_angle,
  output logic signed [23:0] out_swing_velocity
);

  localparam int AF = ANGLE_FRAC_BITS;
  localparam int AW = AF + 3;
  localparam int SW = AW + 1;

  localparam logic [63:0] PI_F   = (PI_Q60 + (64'd1 << (59 - AF))) >> (60 - AF);
  localparam logic [63:0] HALF_F = (PI_Q60 + (64'd1 << (60 - AF))) >> (61 - AF);
  localparam logic [63:0] ANG_RST_F = (PI_Q60 + (64'd1 << (61 - AF))) >> (62 - AF);

  localparam logic signed [AW-1:0] PI_A    = AW'(PI_F);
  localparam logic signed [AW-1:0] HPF_A   = AW'(PI_F >> 1);
  localparam logic signed [AW-1:0] NHPF_A  = AW'(-(PI_F >> 1));
  localparam logic signed [AW-1:0] HALF_A  = AW'(HALF_F);
  localparam logic signed [AW-1:0] NHALF_A = AW'(-HALF_F);
  localparam logic signed [AW-1:0] ANG_RST = AW'(ANG_RST_F);
  localparam logic signed [SW-1:0] PI_S    = SW'(PI_F);
  localparam logic signed [SW-1:0] NPI_S   = SW'(-PI_F);
  localparam logic signed [SW-1:0] TPI_S   = SW'(2 * PI_F);

  localparam logic [4:0] DIV_LAST  = 5'd28;
  localparam logic [4:0] SQRT_LAST = 5'd14;

  typedef enum logic [18:0] {
    S_IDLE = 19'h00001,
    S_COR1 = 19'h00002,
    S_MG   = 19'h00004,
    S_DIVI = 19'h00008,
    S_DIV  = 19'h00010,
    S_VEL  = 19'h00020,
    S_MDEG = 19'h00040,
    S_ANG  = 19'h00080,
    S_VD   = 19'h00100,
    S_COR2 = 19'h00200,
    S_MX   = 19'h00400,
    S_MY   = 19'h00800,
    S_BY   = 19'h01000,
    S_SQX  = 19'h02000,
    S_SQY  = 19'h04000,
    S_SQI  = 19'h08000,
    S_SQRT = 19'h10000,
    S_DATN = 19'h20000,
    S_DONE = 19'h40000
  } state_t;

  state_t state_r, state_nxt;

  // configuration and pendulum state
  logic [9:0]           pivot_x_r, pivot_y_r;
  logic [23:0]          gravity_r;
  logic [16:0]          damping_r;
  logic signed [AW-1:0] angle_r;
  logic signed [23:0]   vel_r;
  logic [14:0]          length_r;

  // working registers
  logic signed [23:0]   v_r;
  logic signed [31:0]   sin_r, cos_r;
  logic                 cor_neg_r;
  logic signed [MW-1:0] prod_r;
  logic [17:0]          rem_r;
  logic [29:0]          shf_r;
  logic [14:0]          root_r;
  logic [4:0]           cnt_r;
  logic signed [10:0]   dx_r, dy_r;
  logic [9:0]           px_r, py_r;
  logic [21:0]          sq_r;
  logic signed [15:0]   bx_r, by_r;

  // output register
  logic                 out_valid_r;
  logic signed [15:0]   out_bob_x_r, out_bob_y_r;
  logic signed [18:0]   out_ang_r;
  logic signed [23:0]   out_vel_r;

  logic                 in_xfer, out_xfer;
  cor_req_t             cor_req;
  logic                 cor_busy;
  logic signed [CW-1:0] cor_x, cor_y, cor_z;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid_r && out_ready;

  // angle range reduction into [-pi/2, pi/2] for the sine pass
  logic signed [AW-1:0] red_a;
  logic                 red_neg;
  always_comb begin
    if (angle_r > HPF_A) begin
      red_a   = angle_r - PI_A;
      red_neg = 1'b1;
    end else if (angle_r < NHPF_A) begin
      red_a   = angle_r + PI_A;
      red_neg = 1'b1;
    end else begin
      red_a   = angle_r;
      red_neg = 1'b0;
    end
  end

  // drag offsets, magnitudes
  logic [9:0] adx, ady;
  assign adx = dx_r[10] ? 10'(-dx_r) : dx_r[9:0];
  assign ady = dy_r[10] ? 10'(-dy_r) : dy_r[9:0];

  // CORDIC request
  always_comb begin
    cor_req.start = (state_r == S_IDLE && in_xfer && !in_func) ||
                    (state_r == S_VD) || (state_r == S_SQI);
    cor_req.vec   = (state_r == S_SQI);
    if (state_r == S_SQI) begin
      cor_req.x0 = CW'({ady, 20'b0});
      cor_req.y0 = CW'({adx, 20'b0});
      cor_req.z0 = '0;
    end else begin
      cor_req.x0 = CW'(GAIN_Q30);
      cor_req.y0 = '0;
      cor_req.z0 = CW'(red_a) <<< (30 - AF);
    end
  end

  dps_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cor_req),
    .busy  (cor_busy),
    .x     (cor_x),
    .y     (cor_y),
    .z     (cor_z)
  );

  // shared multiplier operand select
  logic signed [24:0]   mul_a;
  logic signed [31:0]   mul_b;
  logic signed [MW-1:0] mul_p;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_MG: begin
        mul_a = 25'(gravity_r);
        mul_b = sin_r[31] ? -sin_r : sin_r;
      end
      S_MDEG: begin
        mul_a = 25'(v_r);
        mul_b = 32'(DEG_Q32);
      end
      S_ANG: begin
        mul_a = 25'(v_r);
        mul_b = 32'(damping_r);
      end
      S_MX: begin
        mul_a = 25'(length_r);
        mul_b = sin_r;
      end
      S_MY: begin
        mul_a = 25'(length_r);
        mul_b = cos_r;
      end
      S_SQX: begin
        mul_a = 25'(dx_r);
        mul_b = 32'(dx_r);
      end
      S_SQY: begin
        mul_a = 25'(dy_r);
        mul_b = 32'(dy_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = MW'(mul_a) * MW'(mul_b);
  end

  // shared compare and subtract for divider and square root
  logic [17:0] cs_cand, cs_trial, cs_diff;
  logic        cs_ge;
  always_comb begin
    if (state_r == S_SQRT) begin
      cs_cand  = {rem_r[15:0], shf_r[29:28]};
      cs_trial = {1'b0, root_r, 2'b01};
    end else begin
      cs_cand  = {2'b0, rem_r[14:0], shf_r[28]};
      cs_trial = {3'b0, length_r};
    end
    cs_ge   = cs_cand >= cs_trial;
    cs_diff = cs_cand - cs_trial;
  end

  // velocity after acceleration
  logic signed [MW-1:0] acc, vsum, vsat;
  always_comb begin
    if (length_r == '0) acc = '0;
    else if (sin_r > 0) acc = -$signed(MW'(shf_r[28:0]));
    else acc = $signed(MW'(shf_r[28:0]));
    vsum = MW'(vel_r) + acc;
    vsat = sat_w(vsum, 24);
  end

  // angle advance with wrap into [-pi, pi)
  logic signed [MW-1:0] inc;
  logic signed [SW-1:0] ang_sum, ang_wrap;
  always_comb begin
    inc     = rnd_shift(prod_r, 48 - AF);
    ang_sum = SW'(angle_r) + $signed(inc[SW-1:0]);
    if (ang_sum >= PI_S) ang_wrap = ang_sum - TPI_S;
    else if (ang_sum < NPI_S) ang_wrap = ang_sum + TPI_S;
    else ang_wrap = ang_sum;
  end

  // damped velocity and bob coordinate from the product
  logic signed [MW-1:0] vdamp, pos_off, pos_x, pos_y;
  always_comb begin
    vdamp   = sat_w(rnd_shift(prod_r, 16), 24);
    pos_off = rnd_shift(prod_r, 30);
    pos_x   = sat_w($signed(MW'({pivot_x_r, 4'b0})) + pos_off, 16);
    pos_y   = sat_w($signed(MW'({pivot_y_r, 4'b0})) + pos_off, 16);
  end

  // drag angle from the arctangent
  logic signed [MW-1:0] za;
  logic signed [AW-1:0] a_t, ang_drag;
  always_comb begin
    za  = rnd_shift(MW'(cor_z), 30 - AF);
    a_t = za[AW-1:0];
    if (dy_r == 0) begin
      if (dx_r > 0) ang_drag = HALF_A;
      else if (dx_r < 0) ang_drag = NHALF_A;
      else ang_drag = '0;
    end else if (dx_r[10] != dy_r[10]) begin
      ang_drag = -a_t;
    end else begin
      ang_drag = a_t;
    end
  end

  // angle output keeps its low 19 bits
  logic signed [AW+18:0] ang_wide;
  assign ang_wide = {{19{angle_r[AW-1]}}, angle_r};

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_xfer) state_nxt = in_func ? S_SQX : S_COR1;
      S_COR1: if (!cor_busy) state_nxt = S_MG;
      S_MG:   state_nxt = S_DIVI;
      S_DIVI: state_nxt = S_DIV;
      S_DIV:  if (cnt_r == DIV_LAST) state_nxt = S_VEL;
      S_VEL:  state_nxt = S_MDEG;
      S_MDEG: state_nxt = S_ANG;
      S_ANG:  state_nxt = S_VD;
      S_VD:   state_nxt = S_COR2;
      S_COR2: if (!cor_busy) state_nxt = S_MX;
      S_MX:   state_nxt = S_MY;
      S_MY:   state_nxt = S_BY;
      S_BY:   state_nxt = S_DONE;
      S_SQX:  state_nxt = S_SQY;
      S_SQY:  state_nxt = S_SQI;
      S_SQI:  state_nxt = S_SQRT;
      S_SQRT: if (cnt_r == SQRT_LAST) state_nxt = S_DATN;
      S_DATN: if (!cor_busy) state_nxt = S_DONE;
      S_DONE: if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control, configuration and pendulum state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pivot_x_r   <= PIVOT_X_RST;
      pivot_y_r   <= PIVOT_Y_RST;
      gravity_r   <= GRAVITY_RST;
      damping_r   <= DAMPING_RST;
      angle_r     <= ANG_RST;
      vel_r       <= '0;
      length_r    <= LENGTH_RST;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_xfer) out_valid_r <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_PIVOT_X: pivot_x_r <= cfg_data[9:0];
          REG_PIVOT_Y: pivot_y_r <= cfg_data[9:0];
          REG_GRAVITY: gravity_r <= cfg_data;
          REG_DAMPING: damping_r <= 17'(cfg_data);
          default:     pivot_x_r <= pivot_x_r;
        endcase
      end
      if (state_r == S_ANG) angle_r <= ang_wrap[AW-1:0];
      if (state_r == S_VD) vel_r <= vdamp[23:0];
      if (state_r == S_DATN && !cor_busy) begin
        angle_r  <= ang_drag;
        length_r <= root_r;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    if (cor_req.start && !cor_req.vec) cor_neg_r <= red_neg;
    if (state_r == S_IDLE && in_xfer) begin
      px_r <= in_drag_x;
      py_r <= in_drag_y;
      dx_r <= $signed({1'b0, in_drag_x}) - $signed({1'b0, pivot_x_r});
      dy_r <= $signed({1'b0, in_drag_y}) - $signed({1'b0, pivot_y_r});
    end
    if ((state_r == S_COR1 || state_r == S_COR2) && !cor_busy) begin
      sin_r <= cor_neg_r ? 32'(-cor_y) : 32'(cor_y);
      cos_r <= cor_neg_r ? 32'(-cor_x) : 32'(cor_x);
    end
    case (state_r)
      S_DIVI: begin
        shf_r <= {1'b0, prod_r[54:26]};
        rem_r <= '0;
        cnt_r <= '0;
      end
      S_DIV: begin
        rem_r <= cs_ge ? cs_diff : cs_cand;
        shf_r <= {shf_r[28:0], cs_ge};
        cnt_r <= cnt_r + 5'd1;
      end
      S_VEL:  v_r <= vsat[23:0];
      S_MY:   bx_r <= pos_x[15:0];
      S_BY:   by_r <= pos_y[15:0];
      S_SQY:  sq_r <= prod_r[21:0];
      S_SQI: begin
        shf_r  <= {sq_r + prod_r[21:0], 8'b0};
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= '0;
      end
      S_SQRT: begin
        rem_r  <= cs_ge ? cs_diff : cs_cand;
        root_r <= {root_r[13:0], cs_ge};
        shf_r  <= {shf_r[27:0], 2'b00};
        cnt_r  <= cnt_r + 5'd1;
      end
      S_DATN: begin
        bx_r <= $signed({2'b0, px_r, 4'b0});
        by_r <= $signed({2'b0, py_r, 4'b0});
      end
      default: cnt_r <= cnt_r;
    endcase
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_bob_x_r <= bx_r;
      out_bob_y_r <= by_r;
      out_ang_r   <= ang_wide[18:0];
      out_vel_r   <= vel_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_bob_x          = out_bob_x_r;
  assign out_bob_y          = out_bob_y_r;
  assign out_swing_angle    = out_ang_r;
  assign out_swing_velocity = out_vel_r;

  // sequencer stays one-hot
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  // the CORDIC only runs while the sequencer waits on it or runs the square root
  a_cordic_owner: assert property (@(posedge clk) disable iff (!rst_n)
    cor_busy |-> (state_r == S_COR1 || state_r == S_COR2 ||
                  state_r == S_SQRT || state_r == S_DATN))
    else $error("CORDIC busy outside a waiting state");

  // an accepted item closes the input until it is done
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready)
    else $error("input reopened right after a transfer");

endmodule
